[rtl/lbp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lbp_pkg
// Shared types, constants and the pattern function of the 3x3 LBP operator.
// ---------------------------------------------------------------------------
package lbp_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [10:0] WIDTH_RESET  = 11'd120;
    localparam logic [12:0] HEIGHT_RESET = 13'd140;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PW    = 2;
    localparam int FIFO_CW    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_FLUSH = 1'b1
    } t_req;

    // one window column, rows top to bottom
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_col;

    // control of the word in the compute stage
    typedef struct packed {
        logic valid;
        logic flush;
        logic emit_a;   // first result (left code, or the flushed code)
        logic emit_b;   // second result (row end code)
        logic top;
        logic left_a;
        logic right_a;
        logic left_b;
        logic fend_a;
    } t_s1_ctrl;

    typedef struct packed {
        logic [7:0]  code;
        logic [11:0] row;
        logic [9:0]  col;
        logic        frame_end;
        logic        run_last;
    } t_result;

    // Bit 7..0: top-left, top, top-right, right, bottom-right, bottom,
    // bottom-left, left. Set when the neighbour exists and is at least the centre.
    function automatic logic [7:0] lbp_code(
        input t_col cl,
        input t_col cm,
        input t_col cr,
        input logic top,
        input logic bot,
        input logic left,
        input logic right
    );
        logic [PIX_W-1:0] ctr;
        logic [7:0]       code;
        ctr     = cm.mid;
        code[7] = top && left  && (cl.top >= ctr);
        code[6] = top          && (cm.top >= ctr);
        code[5] = top && right && (cr.top >= ctr);
        code[4] = right        && (cr.mid >= ctr);
        code[3] = bot && right && (cr.bot >= ctr);
        code[2] = bot          && (cm.bot >= ctr);
        code[1] = bot && left  && (cl.bot >= ctr);
        code[0] = left         && (cl.mid >= ctr);
        return code;
    endfunction

endpackage
`default_nettype wire

[rtl/lbp_3x3_operator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lbp_3x3_operator
// Streaming 3x3 local binary pattern of an 8-bit grayscale raster frame.
// ---------------------------------------------------------------------------
// Input channel (i_valid/o_ready): one word per pixel in raster order, or a
// flush word (i_req_type = 1) after the frame to release the last row.
// Output channel (o_valid/i_ready): one word per code, with row, column,
// frame end and a marker on the last code caused by an input word.
// A pixel word at (r,c) yields the code of (r-1,c-1) and, at the row end,
// also that of (r-1,last column); the first row yields nothing.
// Frame size is written through i_cfg_we/i_cfg_index/i_cfg_data between
// frames. Out-of-range sizes are clamped to 1..MAX.
// Throughput: one input word per cycle while o_ready is high. Each row end
// gives two codes, so with a draining receiver input is held at each row
// end until the four-entry result queue has room again. A code is formed
// from the registered line store read and leaves through the result queue.
// Both row stores live in one dual-read RAM; a word written back by the
// compute stage is forwarded to a read of the same column in that cycle.
// Reset: a clearing pass over all line store addresses zeroes the stores,
// with o_ready low throughout; configuration writes are taken as usual.
// When the receiver stalls the queue fills and o_ready drops; nothing is
// lost and o_valid holds its word until taken.
// ---------------------------------------------------------------------------
module lbp_3x3_operator #(
    parameter int MAX_WIDTH  = lbp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = lbp_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration
    input  wire logic                           i_cfg_we,
    input  wire logic [lbp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lbp_pkg::CFG_W-1:0]      i_cfg_data,
    // input words
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic                           i_req_type,
    input  wire logic [7:0]                     i_pixel_value,
    // result words
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [7:0]                          o_pattern_code,
    output logic [11:0]                         o_pixel_row,
    output logic [9:0]                          o_pixel_col,
    output logic                                o_frame_end,
    output logic                                o_run_last
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int MEMW = 2 * lbp_pkg::PIX_W;
    localparam int PW   = lbp_pkg::PIX_W;
    localparam int QPW  = lbp_pkg::FIFO_PW;
    localparam int QCW  = lbp_pkg::FIFO_CW;

    localparam logic [CW:0]     W_MAX   = (CW+1)'(MAX_WIDTH);
    localparam logic [RW:0]     H_MAX   = (RW+1)'(MAX_HEIGHT);
    localparam logic [CW-1:0]   CLR_END = CW'(MAX_WIDTH - 1);
    localparam logic [QCW:0]    Q_LIMIT = (QCW+1)'(lbp_pkg::FIFO_DEPTH - 2);
    localparam logic [QCW:0]    Q_DEPTH = (QCW+1)'(lbp_pkg::FIFO_DEPTH);

    // ---------------- configuration ----------------
    logic [10:0] r_frame_width;
    logic [12:0] r_frame_height;
    logic [CW:0] eff_w;
    logic [RW:0] eff_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= lbp_pkg::WIDTH_RESET;
            r_frame_height <= lbp_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == lbp_pkg::CFG_FRAME_WIDTH) begin
                r_frame_width <= i_cfg_data[10:0];
            end else begin
                r_frame_height <= i_cfg_data;
            end
        end
    end

    // clamp to 1..MAX
    always_comb begin
        if (r_frame_width == '0) begin
            eff_w = (CW+1)'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            eff_w = W_MAX;
        end else begin
            eff_w = (CW+1)'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            eff_h = (RW+1)'(1);
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            eff_h = H_MAX;
        end else begin
            eff_h = (RW+1)'(r_frame_height);
        end
    end

    // ---------------- state ----------------
    logic                 r_clr_busy;
    logic [CW-1:0]        r_clr_addr;
    logic [RW-1:0]        r_row,   n_row;
    logic [CW-1:0]        r_col,   n_col;
    logic [CW:0]          r_flush_cnt, n_flush_cnt;
    logic                 r_frame_complete, n_frame_complete;

    lbp_pkg::t_s1_ctrl    r_s1, n_s1;
    logic [11:0]          r_s1_row, n_s1_row;
    logic [9:0]           r_s1_col_a, n_s1_col_a;
    logic [9:0]           r_s1_col_b, n_s1_col_b;
    logic [CW-1:0]        r_s1_addr, n_s1_addr;
    logic [PW-1:0]        r_s1_pix;

    logic                 r_fwd_a, r_fwd_b;
    logic [MEMW-1:0]      r_fwd_data;

    lbp_pkg::t_col        r_win [3];        // left, mid, right columns
    logic [MEMW-1:0]      r_flush_left;     // {older,newer} of column k-1

    lbp_pkg::t_result     r_fifo [lbp_pkg::FIFO_DEPTH];
    logic [QPW-1:0]       r_wr_ptr, r_rd_ptr;
    logic [QCW-1:0]       r_count;

    // ---------------- accept stage ----------------
    logic            acc, acc_pix, acc_fl, fl_ok;
    logic [RW-1:0]   row0;
    logic [CW-1:0]   col0;
    logic [RW:0]     row1;
    logic [CW-1:0]   col1;
    logic [RW-1:0]   pr;
    logic [CW-1:0]   pc;
    logic            c_last, r_last;
    logic [CW:0]     k, k_p1;
    logic [CW-1:0]   ra_a, ra_b;
    logic [1:0]      s1_n;
    logic            s1_we;
    logic [CW-1:0]   wa;
    logic [MEMW-1:0] wd;
    logic            ram_we;
    logic [MEMW-1:0] ram_rd_a, ram_rd_b;

    assign s1_n    = {1'b0, r_s1.emit_a} + {1'b0, r_s1.emit_b};
    assign o_ready = !r_clr_busy &&
                     (({1'b0, r_count} + {{(QCW-1){1'b0}}, s1_n}) <= Q_LIMIT);

    assign acc     = i_valid && o_ready;
    assign k       = r_flush_cnt;
    assign k_p1    = r_flush_cnt + (CW+1)'(1);
    assign fl_ok   = r_frame_complete && (k < eff_w);
    assign acc_pix = acc && (i_req_type == lbp_pkg::REQ_PIXEL);
    assign acc_fl  = acc && (i_req_type == lbp_pkg::REQ_FLUSH) && fl_ok;

    // position of this pixel: new frame after completion, row wrap when the
    // width shrank, frame wrap when the height shrank
    always_comb begin
        row0 = r_frame_complete ? '0 : r_row;
        col0 = r_frame_complete ? '0 : r_col;
        if ({1'b0, col0} >= eff_w) begin
            row1 = {1'b0, row0} + (RW+1)'(1);
            col1 = '0;
        end else begin
            row1 = {1'b0, row0};
            col1 = col0;
        end
        if (row1 >= eff_h) begin
            row1 = '0;
            col1 = '0;
        end
        pr     = row1[RW-1:0];
        pc     = col1;
        c_last = ({1'b0, pc} + (CW+1)'(1)) >= eff_w;
        r_last = ({1'b0, pr} + (RW+1)'(1)) >= eff_h;
    end

    assign ra_a = (i_req_type == lbp_pkg::REQ_PIXEL) ? pc : k[CW-1:0];
    assign ra_b = k_p1[CW-1:0];

    // frame counters
    always_comb begin
        n_row            = r_row;
        n_col            = r_col;
        n_flush_cnt      = r_flush_cnt;
        n_frame_complete = r_frame_complete;
        if (acc_pix) begin
            n_flush_cnt = '0;
            if (c_last) begin
                n_col = '0;
                if (r_last) begin
                    n_frame_complete = 1'b1;
                    n_row            = pr;
                end else begin
                    n_frame_complete = 1'b0;
                    n_row            = pr + RW'(1);
                end
            end else begin
                n_frame_complete = 1'b0;
                n_col            = pc + CW'(1);
                n_row            = pr;
            end
        end else if (acc_fl) begin
            n_flush_cnt = k_p1;
        end
    end

    // compute-stage control
    always_comb begin
        n_s1       = '0;
        n_s1_row   = 12'(32'(pr) - 32'd1);
        n_s1_col_a = 10'(32'(pc) - 32'd1);
        n_s1_col_b = 10'(pc);
        n_s1_addr  = pc;
        if (acc_pix) begin
            n_s1.valid   = 1'b1;
            n_s1.emit_a  = (pr != '0) && (pc != '0);
            n_s1.emit_b  = (pr != '0) && c_last;
            n_s1.top     = 32'(pr) >= 32'd2;
            n_s1.left_a  = 32'(pc) >= 32'd2;
            n_s1.right_a = 1'b1;
            n_s1.left_b  = pc != '0;
        end else if (acc_fl) begin
            // last row: no bottom neighbours
            n_s1.valid   = 1'b1;
            n_s1.flush   = 1'b1;
            n_s1.emit_a  = 1'b1;
            n_s1.top     = 32'(eff_h) >= 32'd2;
            n_s1.left_a  = k != '0;
            n_s1.right_a = k_p1 < eff_w;
            n_s1.fend_a  = k_p1 == eff_w;
            n_s1_row     = 12'(32'(eff_h) - 32'd1);
            n_s1_col_a   = 10'(k);
        end
    end

    // ---------------- line store ----------------
    // word = {older row, newer row}; a pixel shifts newer into older
    logic [MEMW-1:0] rd_a, rd_b;

    assign rd_a   = r_fwd_a ? r_fwd_data : ram_rd_a;
    assign rd_b   = r_fwd_b ? r_fwd_data : ram_rd_b;
    assign s1_we  = r_s1.valid && !r_s1.flush;
    assign wd     = r_clr_busy ? '0 : {rd_a[PW-1:0], r_s1_pix};
    assign wa     = r_clr_busy ? r_clr_addr : r_s1_addr;
    assign ram_we = r_clr_busy || s1_we;

    lbp_ram #(
        .WIDTH (MEMW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (wa),
        .i_wdata   (wd),
        .i_raddr_a (ra_a),
        .i_raddr_b (ra_b),
        .o_rdata_a (ram_rd_a),
        .o_rdata_b (ram_rd_b)
    );

    // ---------------- compute stage ----------------
    lbp_pkg::t_col    new_col, cl_f, cm_f, cr_f;
    logic [7:0]       code_a, code_b;
    lbp_pkg::t_result res_a, res_b;

    always_comb begin
        new_col = lbp_pkg::t_col'{top: rd_a[MEMW-1:PW], mid: rd_a[PW-1:0], bot: r_s1_pix};
        cl_f    = lbp_pkg::t_col'{top: r_flush_left[MEMW-1:PW], mid: r_flush_left[PW-1:0],
                                  bot: '0};
        cm_f    = lbp_pkg::t_col'{top: rd_a[MEMW-1:PW], mid: rd_a[PW-1:0], bot: '0};
        cr_f    = lbp_pkg::t_col'{top: rd_b[MEMW-1:PW], mid: rd_b[PW-1:0], bot: '0};
        if (r_s1.flush) begin
            code_a = lbp_pkg::lbp_code(cl_f, cm_f, cr_f, r_s1.top, 1'b0,
                                       r_s1.left_a, r_s1.right_a);
        end else begin
            code_a = lbp_pkg::lbp_code(r_win[1], r_win[2], new_col, r_s1.top, 1'b1,
                                       r_s1.left_a, r_s1.right_a);
        end
        code_b = lbp_pkg::lbp_code(r_win[2], new_col, '0, r_s1.top, 1'b1,
                                   r_s1.left_b, 1'b0);
        res_a  = lbp_pkg::t_result'{code: code_a, row: r_s1_row, col: r_s1_col_a,
                                    frame_end: r_s1.fend_a, run_last: !r_s1.emit_b};
        res_b  = lbp_pkg::t_result'{code: code_b, row: r_s1_row, col: r_s1_col_b,
                                    frame_end: 1'b0, run_last: 1'b1};
    end

    // ---------------- result queue ----------------
    logic pop;
    assign o_valid        = r_count != '0;
    assign pop            = o_valid && i_ready;
    assign o_pattern_code = r_fifo[r_rd_ptr].code;
    assign o_pixel_row    = r_fifo[r_rd_ptr].row;
    assign o_pixel_col    = r_fifo[r_rd_ptr].col;
    assign o_frame_end    = r_fifo[r_rd_ptr].frame_end;
    assign o_run_last     = r_fifo[r_rd_ptr].run_last;

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy       <= 1'b1;
            r_clr_addr       <= '0;
            r_row            <= '0;
            r_col            <= '0;
            r_flush_cnt      <= '0;
            r_frame_complete <= 1'b0;
            r_s1             <= '0;
            r_wr_ptr         <= '0;
            r_rd_ptr         <= '0;
            r_count          <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + CW'(1);
                if (r_clr_addr == CLR_END) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_row            <= n_row;
            r_col            <= n_col;
            r_flush_cnt      <= n_flush_cnt;
            r_frame_complete <= n_frame_complete;
            r_s1             <= n_s1;
            r_wr_ptr         <= r_wr_ptr + QPW'(s1_n);
            r_rd_ptr         <= r_rd_ptr + QPW'(pop);
            r_count          <= r_count + QCW'(s1_n) - QCW'(pop);
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_s1_row   <= n_s1_row;
        r_s1_col_a <= n_s1_col_a;
        r_s1_col_b <= n_s1_col_b;
        r_s1_addr  <= n_s1_addr;
        r_s1_pix   <= i_pixel_value;
        // write-back collides with a read in the same cycle: forward
        r_fwd_a    <= s1_we && (r_s1_addr == ra_a);
        r_fwd_b    <= s1_we && (r_s1_addr == ra_b);
        r_fwd_data <= wd;
        if (s1_we) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= new_col;
        end
        if (r_s1.valid && r_s1.flush) begin
            r_flush_left <= rd_a;
        end
        if (r_s1.emit_a) begin
            r_fifo[r_wr_ptr] <= res_a;
        end
        if (r_s1.emit_b) begin
            r_fifo[r_wr_ptr + QPW'(r_s1.emit_a)] <= res_b;
        end
    end

    // ---------------- assertions ----------------
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(lbp_pkg::FIFO_DEPTH))
        else $error("result queue overfull");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1.valid |-> (({1'b0, r_count} + {{(QCW-1){1'b0}}, s1_n}) <= Q_DEPTH))
        else $error("compute stage pushes into a full queue");

    a_done_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_complete |-> (r_col == '0))
        else $error("frame complete with column not at zero");

    a_pix_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_pix |=> (r_s1.valid && !r_s1.flush))
        else $error("accepted pixel missing from compute stage");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |=> !r_s1.valid)
        else $error("word processed during line store clear");

endmodule
`default_nettype wire

[rtl/lbp_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lbp_ram
// Generic RAM: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
module lbp_ram #(
    parameter int  WIDTH = 16,
    parameter int  DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read-first: a read of the address being written returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
`default_nettype wire
